// File: src/wrm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wrm_pkg: shared constants and types for the windowed RMS meter
// Field widths, datapath widths and the control state encoding.
// ----------------------------------------------------------------------------
package wrm_pkg;

  localparam int MAX_WINDOW  = 256;
  localparam int SAMPLE_BITS = 16;

  localparam int WLEN_W      = 9;
  localparam int WLEN_RESET  = 32;
  localparam int MEAN_W      = 2 * SAMPLE_BITS - 1;
  localparam int RMS_W       = SAMPLE_BITS;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int SUM_W       = MEAN_W + $clog2(MAX_WINDOW);
  localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W       = (WLEN_W > LEN_W) ? WLEN_W : LEN_W;
  localparam int STEP_W      = $clog2(SUM_W);
  localparam int SQ_SRC_W    = SUM_W + (SUM_W % 2);
  localparam int ROOT_W      = SQ_SRC_W / 2;
  localparam int SQ_REM_W    = ROOT_W + 1;
  localparam int OUT_TDATA_W = ((MEAN_W + RMS_W + 7) / 8) * 8;
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } state_t;

endpackage : wrm_pkg
`default_nettype wire

// File: src/windowed_rms_meter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_rms_meter: mean square and RMS of signed samples over a window
// One input word is one signed sample. The sample is squared with a
// bit-serial shift-add multiplier (one multiplier bit per cycle) and added to
// a running sum. A word that does not close the window then returns the
// core to idle for the next word. The word that closes it also runs
// a restoring divider (one quotient bit per cycle) and a digit-by-digit
// square root of the full quotient (two radicand bits per cycle), and then
// loads the output register as soon as that register is free.
// mean_square is the low 31 bits of the quotient and rms_value the low 16
// bits of its root; both only exceed range after a window is shortened while
// partly filled. The output register frees the core, so a pending result does
// not hold up the next sample unless a second result is ready before the
// first is taken. cfg_wdata of 0 acts as 1; values above 256 act as 256.
// Writing the length does not clear a window in flight.
// ----------------------------------------------------------------------------
module windowed_rms_meter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [wrm_pkg::WLEN_W-1:0]        cfg_wdata,    // window_length
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  input  wire logic [wrm_pkg::IN_TDATA_W-1:0]    in_tdata,     // [15:0] sample
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  output      logic [wrm_pkg::OUT_TDATA_W-1:0]   out_tdata     // [30:0] mean_square,
                                                                // [46:31] rms_value
);
  import wrm_pkg::*;

  state_t                  state_r, state_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [WLEN_W-1:0]       wlen_r;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [LEN_W-1:0]        cnt_r, cnt_nxt;
  logic [SAMPLE_BITS-1:0]  mag_r, mag_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [SUM_W-1:0]        work_r, work_nxt;
  logic [LEN_W-1:0]        rem_r, rem_nxt;
  logic [LEN_W-1:0]        dlen_r, dlen_nxt;
  logic [MEAN_W-1:0]       mean_r, mean_nxt;
  logic [SQ_SRC_W-1:0]     sq_src_r, sq_src_nxt;
  logic [SQ_REM_W-1:0]     sq_rem_r, sq_rem_nxt;
  logic [ROOT_W-1:0]       root_r, root_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [MEAN_W-1:0]       out_mean_r, out_mean_nxt;
  logic [RMS_W-1:0]        out_rms_r, out_rms_nxt;

  logic [SAMPLE_BITS-1:0]  raw;
  logic [SAMPLE_BITS:0]    mul_hi;
  logic [LEN_W-1:0]        eff_len;
  logic [LEN_W-1:0]        cnt_inc;
  logic [LEN_W:0]          div_sh;
  logic                    div_ge;
  logic [SQ_REM_W+1:0]     sq_sh;
  logic [SQ_REM_W+1:0]     sq_trial;
  logic                    sq_ge;
  logic                    out_free;

  // effective window length: 0 acts as 1, saturate at MAX_WINDOW
  always_comb begin
    if (wlen_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (CMP_W'(wlen_r) > CMP_W'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(wlen_r);
    end
  end

  assign raw      = in_tdata[SAMPLE_BITS-1:0];
  assign mul_hi   = {1'b0, prod_r[PROD_W-1:SAMPLE_BITS]}
                  + (prod_r[0] ? {1'b0, mag_r} : '0);
  assign cnt_inc  = cnt_r + LEN_W'(1);
  assign div_sh   = {rem_r, work_r[SUM_W-1]};
  assign div_ge   = div_sh >= {1'b0, dlen_r};
  assign sq_sh    = {sq_rem_r, sq_src_r[SQ_SRC_W-1:SQ_SRC_W-2]};
  assign sq_trial = (SQ_REM_W+2)'({root_r, 2'b01});
  assign sq_ge    = sq_sh >= sq_trial;
  assign out_free = !out_valid_r || out_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_rms_r, out_mean_r});

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    mag_nxt       = mag_r;
    prod_nxt      = prod_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    dlen_nxt      = dlen_r;
    mean_nxt      = mean_r;
    sq_src_nxt    = sq_src_r;
    sq_rem_nxt    = sq_rem_r;
    root_nxt      = root_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_mean_nxt  = out_mean_r;
    out_rms_nxt   = out_rms_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mag_nxt   = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
          prod_nxt  = {{SAMPLE_BITS{1'b0}}, mag_nxt};
          step_nxt  = STEP_W'(SAMPLE_BITS - 1);
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt = {mul_hi, prod_r[SAMPLE_BITS-1:1]};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (cnt_inc >= eff_len) begin
          work_nxt  = sum_r + SUM_W'(prod_r);
          rem_nxt   = '0;
          dlen_nxt  = eff_len;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          step_nxt  = STEP_W'(SUM_W - 1);
          state_nxt = ST_DIV;
        end else begin
          sum_nxt   = sum_r + SUM_W'(prod_r);
          cnt_nxt   = cnt_inc;
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? LEN_W'(div_sh - {1'b0, dlen_r}) : div_sh[LEN_W-1:0];
        work_nxt = {work_r[SUM_W-2:0], div_ge};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          mean_nxt   = work_nxt[MEAN_W-1:0];
          sq_src_nxt = SQ_SRC_W'(work_nxt);
          sq_rem_nxt = '0;
          root_nxt   = '0;
          step_nxt   = STEP_W'(ROOT_W - 1);
          state_nxt  = ST_SQRT;
        end
      end
      ST_SQRT: begin
        sq_rem_nxt = sq_ge ? SQ_REM_W'(sq_sh - sq_trial) : SQ_REM_W'(sq_sh);
        root_nxt   = {root_r[ROOT_W-2:0], sq_ge};
        sq_src_nxt = {sq_src_r[SQ_SRC_W-3:0], 2'b00};
        step_nxt   = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = mean_r;
          out_rms_nxt   = root_r[RMS_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      wlen_r      <= WLEN_W'(WLEN_RESET);
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        wlen_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    prod_r     <= prod_nxt;
    work_r     <= work_nxt;
    rem_r      <= rem_nxt;
    dlen_r     <= dlen_nxt;
    mean_r     <= mean_nxt;
    sq_src_r   <= sq_src_nxt;
    sq_rem_r   <= sq_rem_nxt;
    root_r     <= root_nxt;
    out_mean_r <= out_mean_nxt;
    out_rms_r  <= out_rms_nxt;
  end

endmodule : windowed_rms_meter
`default_nettype wire

// File: src/wrm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wrm_port_checks: port-level checks for the windowed RMS meter
// Watches the handshakes on both channels; bound to the top level.
// ----------------------------------------------------------------------------
module wrm_port_checks (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [wrm_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import wrm_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("sample accepted while squarer busy");

  a_handshake_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_tready, out_tvalid}))
    else $error("handshake output unknown");

endmodule : wrm_port_checks

bind windowed_rms_meter wrm_port_checks u_wrm_port_checks (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
